FILE: hdl/ges_pkg.sv
// Shared types, constants and cell functions for the glyph edge smoothing rasterizer.
package ges_pkg;

  // Glyph geometry limits.
  localparam int MAX_WIDTH  = 32;
  localparam int MAX_HEIGHT = 64;

  // Alpha codes for drawn cells.
  localparam logic [7:0] ALPHA_SOLID = 8'd255;
  localparam logic [7:0] ALPHA_ONE   = 8'd112;
  localparam logic [7:0] ALPHA_TWO   = 8'd72;
  localparam logic [7:0] ALPHA_MORE  = 8'd48;
  localparam logic [7:0] ALPHA_NONE  = 8'd0;

  // Configuration register indexes.
  localparam logic [2:0] REG_SMOOTH   = 3'd0;
  localparam logic [2:0] REG_WIDTH    = 3'd1;
  localparam logic [2:0] REG_SCALE_X  = 3'd2;
  localparam logic [2:0] REG_SCALE_Y  = 3'd3;
  localparam logic [2:0] REG_ORIGIN_X = 3'd4;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd5;
  localparam logic [2:0] REG_OFFSET_Y = 3'd6;
  localparam logic [2:0] REG_COLOR    = 3'd7;

  // One block command as it travels to the output register.
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  alpha;
    logic        last;
  } result_t;

  // What the cell evaluator reports for the current column.
  typedef struct packed {
    logic [7:0] alpha;
    logic       more_here;
    logic       any_next;
  } eval_t;

  // Columns at or beyond the width are forced to empty.
  function automatic logic [31:0] width_mask(input logic [5:0] w);
    width_mask = ~(32'hFFFF_FFFF >> w);
  endfunction

  // A cell is drawn when set, or when empty with a set neighbor and smoothing on.
  function automatic logic [31:0] drawn_mask(input logic [31:0] above,
                                             input logic [31:0] mid,
                                             input logic [31:0] below,
                                             input logic [5:0]  w,
                                             input logic        smooth);
    logic [31:0] wm;
    logic [31:0] m;
    logic [31:0] nb;
    wm = width_mask(w);
    m  = mid & wm;
    nb = (m >> 1) | (m << 1) | (above & wm) | (below & wm);
    drawn_mask = (m | (smooth ? nb : 32'd0)) & wm;
  endfunction

  // Alpha of one column; column c sits at bit 31 - c.
  function automatic logic [7:0] cell_alpha(input logic [31:0] above,
                                            input logic [31:0] mid,
                                            input logic [31:0] below,
                                            input logic [5:0]  w,
                                            input logic        smooth,
                                            input logic [4:0]  col);
    logic [31:0] wm;
    logic [31:0] m;
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] a;
    logic [31:0] b;
    logic [4:0]  i;
    logic [2:0]  k;
    wm = width_mask(w);
    m  = mid & wm;
    l  = m >> 1;
    r  = m << 1;
    a  = above & wm;
    b  = below & wm;
    i  = ~col;
    k  = {2'd0, l[i]} + {2'd0, r[i]} + {2'd0, a[i]} + {2'd0, b[i]};
    if (m[i]) begin
      cell_alpha = ALPHA_SOLID;
    end else if (!smooth || k == 3'd0) begin
      cell_alpha = ALPHA_NONE;
    end else if (k == 3'd1) begin
      cell_alpha = ALPHA_ONE;
    end else if (k == 3'd2) begin
      cell_alpha = ALPHA_TWO;
    end else begin
      cell_alpha = ALPHA_MORE;
    end
  endfunction

endpackage

FILE: hdl/ges_cell_eval.sv
// Neighbor evaluation of the current column and lookahead over the rest of the glyph row.
module ges_cell_eval (
  input  logic [31:0]         above,
  input  logic [31:0]         mid,
  input  logic [31:0]         below,
  input  logic [5:0]          eff_w,
  input  logic                smooth,
  input  logic [4:0]          col,
  input  logic                second,
  output ges_pkg::eval_t      eval
);

  logic [31:0] drawn_here;
  logic [31:0] drawn_next;
  logic [31:0] after_col;

  // Drawn cells of this row and of the row that follows it in the same word.
  assign drawn_here = ges_pkg::drawn_mask(above, mid, below, eff_w, smooth);
  assign drawn_next = ges_pkg::drawn_mask(mid, below, 32'd0, eff_w, smooth);

  // Columns strictly to the right of the current one.
  assign after_col = (32'hFFFF_FFFF >> col) >> 1;

  assign eval.alpha     = ges_pkg::cell_alpha(above, mid, below, eff_w, smooth, col);
  assign eval.more_here = |(drawn_here & after_col);
  assign eval.any_next  = second && (|drawn_next);

endmodule

FILE: hdl/ges_out_reg.sv
// Output register that holds one block command until the receiver takes it.
module ges_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  ges_pkg::result_t  din,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       block_x,
  output logic [15:0]       block_y,
  output logic [7:0]        alpha,
  output logic              run_last
);

  ges_pkg::result_t held;

  // The register can take a new word when empty or when its word leaves now.
  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= din;
    end
  end

  assign block_x  = held.x;
  assign block_y  = held.y;
  assign alpha    = held.alpha;
  assign run_last = held.last;

endmodule

FILE: hdl/glyph_edge_smooth_raster.sv
// Top level of the glyph edge smoothing rasterizer: window, column sequencer, configuration.
//
// Glyph rows enter one word per item on the input channel (in_valid / in_stall),
// column 0 at bit 31 of row_bits, last_row on the final row of a glyph. Each
// row is drawn once its lower neighbor has arrived; the final row is drawn at
// once behind it. Block commands leave on the output channel (out_valid /
// out_stall), one word per drawn cell in column order, run_last on the final
// word caused by one input word.
// An accepted row is scanned by one column evaluator at one column per cycle,
// over the glyph width capped at 32, and then over the final row when it is
// flushed as well; a drawn column waits while the output register holds a
// stalled word. A word that draws no row (width 0, nothing pending and not
// final, or past the height limit) leaves the block idle for the next word.
// in_stall is high for the whole scan.
// Configuration is written through cfg_write / cfg_index / cfg_data; the user must keep
// to writing only while the block is idle, which the block does not enforce. Synchronous
// reset clears the row window and out_valid, loads width 8, scale 1 and other config zero.
module glyph_edge_smooth_raster (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] row_bits,
  input  logic        last_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] block_x,
  output logic [15:0] block_y,
  output logic [7:0]  alpha,
  output logic        run_last
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  // Configuration registers.
  logic        smooth_enable;
  logic [5:0]  glyph_width;
  logic [4:0]  scale_x;
  logic [4:0]  scale_y;
  logic [15:0] origin_x;
  logic [15:0] origin_y;
  logic [15:0] offset_y;
  logic [31:0] draw_color;

  // Row window.
  logic [31:0] row_above;
  logic [31:0] row_pending;
  logic        pending_valid;
  logic [6:0]  row_count;

  // Scan state.
  logic        state;
  logic [31:0] cur_above;
  logic [31:0] cur_mid;
  logic [31:0] cur_below;
  logic        second;
  logic [4:0]  col;
  logic [15:0] x_acc;
  logic [15:0] y_acc;

  logic [5:0]  eff_w;
  logic [4:0]  sx;
  logic [4:0]  sy;
  logic        accept;
  logic        full;
  logic        pass_one;
  logic        pass_two;
  logic [31:0] load_below;
  logic [6:0]  load_row;
  logic [11:0] row_offset;
  logic        drawn;
  logic        out_free;
  logic        step;
  logic        col_end;
  ges_pkg::eval_t   eval;
  ges_pkg::result_t res;

  assign eff_w = (glyph_width > 6'(ges_pkg::MAX_WIDTH)) ? 6'(ges_pkg::MAX_WIDTH) : glyph_width;
  assign sx    = (scale_x == 5'd0) ? 5'd1 : scale_x;
  assign sy    = (scale_y == 5'd0) ? 5'd1 : scale_y;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_enable <= 1'b0;
      glyph_width   <= 6'd8;
      scale_x       <= 5'd1;
      scale_y       <= 5'd1;
      origin_x      <= 16'd0;
      origin_y      <= 16'd0;
      offset_y      <= 16'd0;
      draw_color    <= 32'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ges_pkg::REG_SMOOTH:   smooth_enable <= cfg_data[0];
        ges_pkg::REG_WIDTH:    glyph_width   <= cfg_data[5:0];
        ges_pkg::REG_SCALE_X:  scale_x       <= cfg_data[4:0];
        ges_pkg::REG_SCALE_Y:  scale_y       <= cfg_data[4:0];
        ges_pkg::REG_ORIGIN_X: origin_x      <= cfg_data[15:0];
        ges_pkg::REG_ORIGIN_Y: origin_y      <= cfg_data[15:0];
        ges_pkg::REG_OFFSET_Y: offset_y      <= cfg_data[15:0];
        ges_pkg::REG_COLOR:    draw_color    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Which rows an accepted word draws.
  assign in_stall   = (state != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign full       = (row_count >= 7'(ges_pkg::MAX_HEIGHT));
  assign pass_one   = pending_valid && (!full || last_row) && (eff_w != 6'd0);
  assign pass_two   = !full && last_row && (eff_w != 6'd0);
  assign load_below = full ? 32'd0 : row_bits;
  assign load_row   = pass_one ? (row_count - 7'd1) : row_count;
  assign row_offset = {5'd0, load_row} * {7'd0, sy};

  // Window update on each accepted row.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_above     <= 32'd0;
      row_pending   <= 32'd0;
      pending_valid <= 1'b0;
      row_count     <= 7'd0;
    end else if (accept) begin
      if (last_row) begin
        row_above     <= 32'd0;
        row_pending   <= 32'd0;
        pending_valid <= 1'b0;
        row_count     <= 7'd0;
      end else if (!full) begin
        row_above     <= pending_valid ? row_pending : 32'd0;
        row_pending   <= row_bits;
        pending_valid <= 1'b1;
        row_count     <= row_count + 7'd1;
      end
    end
  end

  ges_cell_eval u_eval (
    .above  (cur_above),
    .mid    (cur_mid),
    .below  (cur_below),
    .eff_w  (eff_w),
    .smooth (smooth_enable),
    .col    (col),
    .second (second),
    .eval   (eval)
  );

  // One column per cycle; a drawn column waits for room in the output register.
  assign drawn    = (eval.alpha != ges_pkg::ALPHA_NONE);
  assign step     = (state == ST_SCAN) && (!drawn || out_free);
  assign col_end  = ({1'b0, col} == (eff_w - 6'd1));

  assign res.x     = x_acc;
  assign res.y     = y_acc;
  assign res.alpha = eval.alpha;
  assign res.last  = !eval.more_here && !eval.any_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (accept) begin
      state <= (pass_one || pass_two) ? ST_SCAN : ST_IDLE;
    end else if (step && col_end && !second) begin
      state <= ST_IDLE;
    end
  end

  // Scan registers: load on accept, advance a column per step, move to the flushed row.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_above <= pass_one ? row_above : 32'd0;
      cur_mid   <= pass_one ? row_pending : row_bits;
      cur_below <= pass_one ? load_below : 32'd0;
      second    <= pass_one && pass_two;
      col       <= 5'd0;
      x_acc     <= origin_x;
      y_acc     <= origin_y + offset_y + {4'd0, row_offset};
    end else if (step) begin
      if (col_end) begin
        cur_above <= cur_mid;
        cur_mid   <= cur_below;
        cur_below <= 32'd0;
        second    <= 1'b0;
        col       <= 5'd0;
        x_acc     <= origin_x;
        y_acc     <= y_acc + {11'd0, sy};
      end else begin
        col   <= col + 5'd1;
        x_acc <= x_acc + {11'd0, sx};
      end
    end
  end

  ges_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && drawn),
    .din       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .block_x   (block_x),
    .block_y   (block_y),
    .alpha     (alpha),
    .run_last  (run_last)
  );

  // The scan column stays inside the glyph width.
  a_col_in_width: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> ({1'b0, col} < eff_w))
    else $error("scan column beyond glyph width");

  // A drawn column is never written over a word that is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (step && drawn) |-> (!out_valid || !out_stall))
    else $error("output word overwritten while stalled");

  // The flushed row pass only starts from the end of the first row pass.
  a_second_pass: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && $past(state == ST_SCAN) && $fell(second)) |-> (col == 5'd0))
    else $error("second row pass started mid row");

  // No word is left unmarked when the scan ends with a drawn last column.
  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    (step && drawn && col_end && !second) |=> (out_valid && run_last))
    else $error("final word of a row not marked");

endmodule
